// ----- src/apf_pkg.sv -----
package apf_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_RED_MASK   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GREEN_MASK = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLUE_MASK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_MASK = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIDE_OUT   = 3'd4;

  localparam int unsigned PixW  = 32;
  localparam int unsigned ChanW = 8;
  localparam int unsigned NumCh = 4;

  // Channel slots: red, green, blue, alpha
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  // Reset values
  localparam logic [PixW-1:0] RST_RED_MASK   = 32'h00FF_0000;
  localparam logic [PixW-1:0] RST_GREEN_MASK = 32'h0000_FF00;
  localparam logic [PixW-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
  localparam logic [PixW-1:0] RST_ALPHA_MASK = 32'hFF00_0000;

  // Per-channel placement: mask plus the two shifts derived from it
  typedef struct packed {
    logic [PixW-1:0] mask;
    logic [4:0]      low;     // left shift: lowest set bit
    logic [2:0]      reduce;  // right shift: 8 - span, 0 for wide spans
  } apf_chan_cfg_t;

  function automatic logic [4:0] lowest_set(input logic [PixW-1:0] m);
    logic [4:0] pos;
    pos = '0;
    for (int i = PixW - 1; i >= 0; i--) begin
      if (m[i]) pos = 5'(i);
    end
    return pos;
  endfunction

  function automatic logic [4:0] highest_set(input logic [PixW-1:0] m);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < PixW; i++) begin
      if (m[i]) pos = 5'(i);
    end
    return pos;
  endfunction

  // Build the channel entry; an empty mask zeroes the part anyway
  function automatic apf_chan_cfg_t make_chan(input logic [PixW-1:0] m);
    apf_chan_cfg_t c;
    logic [5:0]    span;
    c.mask = m;
    c.low  = lowest_set(m);
    span   = {1'b0, highest_set(m)} - {1'b0, c.low} + 6'd1;
    if (span > 6'd8) c.reduce = 3'd0;
    else             c.reduce = 3'(6'd8 - span);
    return c;
  endfunction

endpackage

// ----- src/apf_if.sv -----
// Source pixel channel
interface apf_in_if;
  import apf_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

// Converted pixel channel
interface apf_out_if;
  import apf_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] packed_pixel;

  modport source (output valid, output packed_pixel, input ready);
  modport sink   (input valid, input packed_pixel, output ready);
endinterface

// ----- src/apf_cfg.sv -----
module apf_cfg
  import apf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [PixW-1:0]    cfg_wdata,
  output apf_chan_cfg_t      chan_cfg [NumCh],
  output logic               wide_out
);

  apf_chan_cfg_t chan_r [NumCh];
  logic          wide_r;
  apf_chan_cfg_t wr_chan;

  // Shifts are derived once, at write time
  assign wr_chan = make_chan(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r[CH_RED]   <= make_chan(RST_RED_MASK);
      chan_r[CH_GREEN] <= make_chan(RST_GREEN_MASK);
      chan_r[CH_BLUE]  <= make_chan(RST_BLUE_MASK);
      chan_r[CH_ALPHA] <= make_chan(RST_ALPHA_MASK);
      wide_r           <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RED_MASK:   chan_r[CH_RED]   <= wr_chan;
        REG_GREEN_MASK: chan_r[CH_GREEN] <= wr_chan;
        REG_BLUE_MASK:  chan_r[CH_BLUE]  <= wr_chan;
        REG_ALPHA_MASK: chan_r[CH_ALPHA] <= wr_chan;
        REG_WIDE_OUT:   wide_r           <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign chan_cfg = chan_r;
  assign wide_out = wide_r;

endmodule

// ----- src/apf_place.sv -----
module apf_place
  import apf_pkg::*;
(
  input  logic [ChanW-1:0] chan,
  input  apf_chan_cfg_t    cfg,
  output logic [PixW-1:0]  part
);

  logic [ChanW-1:0] kept;

  // Keep the top span bits, move them to the field, clip to the mask
  assign kept = chan >> cfg.reduce;
  assign part = ({{(PixW-ChanW){1'b0}}, kept} << cfg.low) & cfg.mask;

endmodule

// ----- src/argb8888_to_masked_pixel_format_core.sv -----
// Channel | Dir | Handshake     | Payload
// in_if   | in  | valid/ready   | source_pixel[31:0] (A 31..24, R 23..16, G 15..8, B 7..0)
// out_if  | out | valid/ready   | packed_pixel[31:0]
// cfg_*   | in  | write enable  | cfg_idx[2:0], cfg_wdata[31:0]
//
// One item per clock sustained while out_if is ready; an input register, then a result register.
// The four channel placements and their sum sit between those two registers.
// Mask shifts are derived when a mask is written, ready on the next cycle.
// Synchronous active-low reset restores the default ARGB8888 masks and wide output.
// A stall on out_if holds the result; one more item is taken into the input register.
module argb8888_to_masked_pixel_format_core
  import apf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  apf_in_if.sink             in_if,
  apf_out_if.source          out_if,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [PixW-1:0]    cfg_wdata
);

  apf_chan_cfg_t    chan_cfg [NumCh];
  logic             wide_out;
  logic [ChanW-1:0] chan_val [NumCh];
  logic [PixW-1:0]  part     [NumCh];
  logic [PixW-1:0]  sum;
  logic [PixW-1:0]  pixel_nxt;

  logic             s1_valid_r;
  logic [PixW-1:0]  s1_pixel_r;
  logic             out_valid_r;
  logic [PixW-1:0]  out_pixel_r;
  logic             out_take;
  logic             s1_adv;

  apf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .chan_cfg  (chan_cfg),
    .wide_out  (wide_out)
  );

  // Split the source pixel into channels
  assign chan_val[CH_RED]   = s1_pixel_r[23:16];
  assign chan_val[CH_GREEN] = s1_pixel_r[15:8];
  assign chan_val[CH_BLUE]  = s1_pixel_r[7:0];
  assign chan_val[CH_ALPHA] = s1_pixel_r[31:24];

  for (genvar g = 0; g < NumCh; g++) begin : g_place
    apf_place u_place (
      .chan (chan_val[g]),
      .cfg  (chan_cfg[g]),
      .part (part[g])
    );
  end

  // Sum wraps mod 2^32; narrow mode keeps the low half
  assign sum       = part[CH_RED] + part[CH_GREEN] + part[CH_BLUE] + part[CH_ALPHA];
  assign pixel_nxt = wide_out ? sum : {16'h0000, sum[15:0]};

  // Pipeline flow control
  assign out_take    = !out_valid_r || out_if.ready;
  assign s1_adv      = !s1_valid_r || out_take;
  assign in_if.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_adv && in_if.valid) begin
      s1_pixel_r <= in_if.source_pixel;
    end
    if (out_take && s1_valid_r) begin
      out_pixel_r <= pixel_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.packed_pixel = out_pixel_r;

endmodule

// ----- tb/argb8888_to_masked_pixel_format_core_test.sv -----
module argb8888_to_masked_pixel_format_core_test;
  import apf_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int unsigned DRAIN_CYCLES = 4;    // two-stage pipe plus margin
  localparam int unsigned LONG_HOLD = 300;
  localparam logic [CfgIdxW-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [PixW-1:0] cfg_wdata;

  apf_in_if  in_ch ();
  apf_out_if out_ch ();

  argb8888_to_masked_pixel_format_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Local copy of the destination format
  logic [PixW-1:0] fmt_mask [NumCh];
  bit              fmt_wide;

  logic [PixW-1:0] pending_packed [$];
  int unsigned     mismatch_count;
  int unsigned     stuck_cycles;
  bit              tx_idle_on;
  bit              rx_idle_on;
  int unsigned     rx_hold_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Place one 8-bit channel into its destination mask
  function automatic logic [PixW-1:0] place_part(input logic [ChanW-1:0] chan,
                                                 input logic [PixW-1:0] mask);
    logic [PixW-1:0] wide_chan;
    int lo;
    int hi;
    int span;
    int drop;
    bit seen;
    if (mask == '0) return '0;
    lo = 0;
    hi = 0;
    seen = 1'b0;
    for (int i = 0; i < PixW; i++) begin
      if (mask[i]) begin
        if (!seen) begin
          lo = i;
          seen = 1'b1;
        end
        hi = i;
      end
    end
    span = hi - lo + 1;
    // spans wider than a channel keep the whole byte
    drop = (span > ChanW) ? 0 : ChanW - span;
    wide_chan = chan;
    return ((wide_chan >> drop) << lo) & mask;
  endfunction

  function automatic logic [PixW-1:0] pack_pixel(input logic [PixW-1:0] src);
    logic [PixW-1:0] sum;
    sum = place_part(src[23:16], fmt_mask[CH_RED])
        + place_part(src[15:8],  fmt_mask[CH_GREEN])
        + place_part(src[7:0],   fmt_mask[CH_BLUE])
        + place_part(src[31:24], fmt_mask[CH_ALPHA]);
    if (!fmt_wide) sum[PixW-1:16] = '0;
    return sum;
  endfunction

  function automatic logic [PixW-1:0] rand_mask();
    logic [63:0] field;
    int unsigned w;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3, 4: return $urandom();
      default: begin
        w = $urandom_range(1, 12);
        field = ((64'h1 << w) - 64'h1) << $urandom_range(0, 31);
        return field[PixW-1:0];
      end
    endcase
  endfunction

  // Random pixel, bytes sometimes pinned to corner values
  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] px;
    px = $urandom();
    for (int b = 0; b < NumCh; b++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: px[b*ChanW +: ChanW] = 8'h00;
          1: px[b*ChanW +: ChanW] = 8'hFF;
          2: px[b*ChanW +: ChanW] = 8'h80;
          default: px[b*ChanW +: ChanW] = 8'h01;
        endcase
      end
    end
    return px;
  endfunction

  // Send one item, with an optional idle burst ahead of it
  task automatic send_pixel(input logic [PixW-1:0] px);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.source_pixel <= px;
    do @(posedge clk); while (!in_ch.ready);
    pending_packed.push_back(pack_pixel(px));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_packed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PixW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RED_MASK:   fmt_mask[CH_RED] = data;
      REG_GREEN_MASK: fmt_mask[CH_GREEN] = data;
      REG_BLUE_MASK:  fmt_mask[CH_BLUE] = data;
      REG_ALPHA_MASK: fmt_mask[CH_ALPHA] = data;
      REG_WIDE_OUT:   fmt_wide = data[0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] b, input logic [PixW-1:0] a,
                            input logic [PixW-1:0] wide);
    write_reg(REG_RED_MASK, r);
    write_reg(REG_GREEN_MASK, g);
    write_reg(REG_BLUE_MASK, b);
    write_reg(REG_ALPHA_MASK, a);
    write_reg(REG_WIDE_OUT, wide);
  endtask

  // Reset format, corner pixels
  task automatic test_default_format();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8000_0000);
    send_pixel(32'h0080_0000);
    send_pixel(32'h0000_8001);
    send_pixel(32'h0101_0101);
  endtask

  // Narrow output, empty, wide-span, overlapping masks, spare indexes
  task automatic test_mask_cases();
    wait_all_results();
    set_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000, 32'hFFFF_FFFE);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00F8_FC1F);
    send_pixel(32'h8007_0300);
    send_pixel(32'h7F84_8484);
    wait_all_results();
    set_format(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_80FF);
    send_pixel(32'h5A5A_5A5A);
    send_pixel(32'h0000_0000);
    // overlapping fields, carries wrap, low half only
    wait_all_results();
    set_format(32'h0000_FFFF, 32'h0000_FFFF, 32'h0001_FFF0, 32'h8000_0001, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h80C0_E0F0);
    send_pixel(32'h0123_4567);
    // writes to unused indexes must not disturb anything
    wait_all_results();
    for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
      write_reg(CfgIdxW'(idx), 32'h0F0F_0F0F);
    end
    send_pixel(32'hFEDC_BA98);
    send_pixel(32'h1357_9BDF);
    send_pixel(32'hFFFF_FFFF);
  endtask

  task automatic test_random_formats();
    for (int phase = 0; phase < 12; phase++) begin
      wait_all_results();
      set_format(rand_mask(), rand_mask(), rand_mask(), rand_mask(), $urandom());
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (140) send_pixel(rand_pixel());
    end
  endtask

  // Long receiver hold-off fills the pipe, then a full drain
  task automatic test_backpressure();
    wait_all_results();
    set_format(rand_mask(), rand_mask(), rand_mask(), rand_mask(), 32'h1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    @(posedge clk);
    rx_hold_cycles = LONG_HOLD;
    repeat (60) send_pixel(rand_pixel());
    wait_all_results();
    tx_idle_on = 1'b1;
    repeat (40) send_pixel(rand_pixel());
  endtask

  task automatic test_full_rate();
    wait_all_results();
    set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, rand_mask(), 32'h1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (200) send_pixel(rand_pixel());
  endtask

  // Receiver: random stall bursts plus an on-demand long hold
  initial begin
    int unsigned burst;
    burst = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (burst > 0) begin
        out_ch.ready <= 1'b0;
        burst--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        burst = $urandom_range(1, 14) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    logic [PixW-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_packed.size() == 0) begin
        $error("packed_pixel: no item expected, actual %h", out_ch.packed_pixel);
        mismatch_count++;
      end else begin
        want = pending_packed.pop_front();
        if (out_ch.packed_pixel !== want) begin
          $error("packed_pixel: expected %h, actual %h", want, out_ch.packed_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.source_pixel = '0;
    mismatch_count = 0;
    stuck_cycles = 0;
    rx_hold_cycles = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    fmt_mask[CH_RED] = RST_RED_MASK;
    fmt_mask[CH_GREEN] = RST_GREEN_MASK;
    fmt_mask[CH_BLUE] = RST_BLUE_MASK;
    fmt_mask[CH_ALPHA] = RST_ALPHA_MASK;
    fmt_wide = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_format();
    test_mask_cases();
    test_random_formats();
    test_backpressure();
    test_full_rate();

    wait_all_results();
    mismatch_count += pending_packed.size();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
